[sv/bswo_pkg.sv]
// bswo_pkg: shared types and constants for the bounded stack with overwrite
// request/result payload structs, request codes, controller states and commands
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bswo_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned ITEM_BITS_DEF = 32;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e            req_type;
    logic [DATA_W-1:0]    push_data;
    logic [INDEX_W-1:0]   peek_index;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [DATA_W-1:0]    item_data;
    logic [COUNT_W-1:0]   item_count;
    logic                 is_full;
    logic                 is_empty;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

[sv/bswo_ram.sv]
// bswo_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module bswo_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 17
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[sv/bswo_ctrl.sv]
// bswo_ctrl: request sequencer (idle, execute, respond)
// depends on bswo_pkg
`timescale 1ns / 1ps
`default_nettype none
module bswo_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output      logic                busy_o,
  output      logic                done_o,
  output      bswo_pkg::ctrl_cmd_t cmd_o
);
  import bswo_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o    = 1'b1;
    done_o    = 1'b0;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_RESP: begin
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/bswo_dpath.sv]
// bswo_dpath: ring pointers, item count, mode register and the slot store
// depends on bswo_pkg and bswo_ram
`timescale 1ns / 1ps
`default_nettype none
module bswo_dpath #(
  parameter int unsigned DEPTH     = bswo_pkg::DEPTH_DEF,
  parameter int unsigned ITEM_BITS = bswo_pkg::ITEM_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bswo_pkg::ctrl_cmd_t cmd_i,
  input  wire bswo_pkg::req_t      req_i,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_data_i,
  output      bswo_pkg::rsp_t      rsp_o
);
  import bswo_pkg::*;

  localparam int unsigned SLOTS = DEPTH + 1;
  localparam int unsigned PW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned BW    = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned DW    = (ITEM_BITS < DATA_W) ? ITEM_BITS : DATA_W;

  req_t            req_q;
  logic            cyc_q;
  logic [PW-1:0]   top_q, top_d;
  logic [PW-1:0]   bot_q, bot_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            ok_q, ok_d;
  logic            rd_q, rd_d;

  logic            full;
  logic [INDEX_W-1:0] sel_idx;
  logic [BW-1:0]   back_raw, cnt_ext, back_clamp;
  logic [PW-1:0]   back_p, read_slot, top_next;
  logic            ram_we, ram_re;
  logic [DW-1:0]   ram_rdata;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] s);
    ring_next = (s == PW'(SLOTS - 1)) ? '0 : s + PW'(1);
  endfunction

  // request latch (payload)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_q <= 1'b0;
    end else if (cfg_we_i) begin
      cyc_q <= cfg_data_i;
    end
  end

  // slot of the k-th item from the top, clamped to the oldest
  always_comb begin
    full       = (cnt_q == CW'(DEPTH));
    sel_idx    = (req_q.req_type == REQ_POP) ? '0 : req_q.peek_index;
    back_raw   = BW'(sel_idx) + BW'(1);
    cnt_ext    = BW'(cnt_q);
    back_clamp = (back_raw > cnt_ext) ? cnt_ext : back_raw;
    back_p     = PW'(back_clamp);
    read_slot  = (top_q >= back_p) ? (top_q - back_p) : (top_q + PW'(SLOTS) - back_p);
    top_next   = ring_next(top_q);
  end

  always_comb begin
    top_d  = top_q;
    bot_d  = bot_q;
    cnt_d  = cnt_q;
    ok_d   = 1'b0;
    rd_d   = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    case (req_q.req_type)
      REQ_PUSH: begin
        if (!full || cyc_q) begin
          ram_we = cmd_i.exec;
          top_d  = top_next;
          // overwrite of the oldest item pushes the bottom along
          if (top_next == bot_q) bot_d = ring_next(bot_q);
          if (!full) cnt_d = cnt_q + CW'(1);
          ok_d   = 1'b1;
        end
      end
      REQ_POP: begin
        if (cnt_q != '0) begin
          ram_re = cmd_i.exec;
          top_d  = read_slot;
          cnt_d  = cnt_q - CW'(1);
          ok_d   = 1'b1;
          rd_d   = 1'b1;
        end
      end
      REQ_PEEK: begin
        if (cnt_q != '0) begin
          ram_re = cmd_i.exec;
          ok_d   = 1'b1;
          rd_d   = 1'b1;
        end
      end
      REQ_CLEAR: begin
        top_d = '0;
        bot_d = '0;
        cnt_d = '0;
      end
      default: begin
        top_d = top_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      bot_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      top_q <= top_d;
      bot_q <= bot_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q <= ok_d;
      rd_q <= rd_d;
    end
  end

  bswo_ram #(
    .WIDTH (DW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (top_q),
    .wdata_i (DW'(req_q.push_data)),
    .re_i    (ram_re),
    .raddr_i (read_slot),
    .rdata_o (ram_rdata)
  );

  // read data is valid in the respond cycle and held there
  always_comb begin
    rsp_o.ok         = ok_q;
    rsp_o.item_data  = rd_q ? DATA_W'(ram_rdata) : '0;
    rsp_o.item_count = COUNT_W'(cnt_q);
    rsp_o.is_full    = (cnt_q == CW'(DEPTH));
    rsp_o.is_empty   = (cnt_q == '0);
  end

endmodule
`default_nettype wire

[sv/bounded_stack_with_overwrite.sv]
// bounded_stack_with_overwrite: LIFO of DEPTH items in a ring of DEPTH+1 slots
// a start accepted in idle moves the request through the execute state and then the
// respond state, in which done_o is high and the result is taken
// a new request is taken only back in idle, after the respond state that waits for the
// registered read of the slot RAM; results cannot be stalled by the receiver
// reset: pointers, count and cyclic mode clear at once; slot contents are left unset
// depends on bswo_pkg, bswo_ctrl, bswo_dpath, bswo_ram
`timescale 1ns / 1ps
`default_nettype none
module bounded_stack_with_overwrite #(
  parameter int unsigned DEPTH     = bswo_pkg::DEPTH_DEF,
  parameter int unsigned ITEM_BITS = bswo_pkg::ITEM_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output      logic           busy,
  input  wire bswo_pkg::req_t req_i,
  output      logic           done_o,
  output      bswo_pkg::rsp_t rsp_o,
  input  wire logic           cfg_valid_i,
  output      logic           cfg_ready_o,
  input  wire logic           cfg_data_i
);
  import bswo_pkg::*;

  ctrl_cmd_t cmd;
  logic      cfg_we;

  assign cfg_ready_o = ~busy;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  bswo_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  bswo_dpath #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o)
  );

  // an accepted request passes through the execute state before its result
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("request did not enter execution");

  // after a result the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after result");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.is_full && rsp_o.is_empty))
    else $error("full and empty together");

  // a failed or non-read request never carries item data
  a_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.ok) |-> (rsp_o.item_data == '0))
    else $error("item data on failed request");

endmodule
`default_nettype wire
